FILE: src/bwb_pkg.sv
// Shared types and constants for the byte window buffer with search.
// No dependencies; the other files that use it refer to this package by scoped names.
package bwb_pkg;

   localparam int DEFAULT_CAPACITY = 1024;
   localparam int QUEUE_DEPTH      = 2;

   localparam int KIND_W  = 2;
   localparam int BYTE_W  = 8;
   localparam int POS_W   = 10;
   localparam int MIDX_W  = 10;
   localparam int FILL_W  = 11;

   typedef enum logic [KIND_W-1:0] {
      OP_APPEND = 2'd0,
      OP_REMOVE = 2'd1,
      OP_SEARCH = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ_WAIT,
      ST_SEARCH,
      ST_RESULT
   } back_state_type;

   typedef struct packed {
      op_type            op;
      logic [BYTE_W-1:0] data_byte;
      logic [POS_W-1:0]  position;
   } cmd_type;

endpackage

FILE: src/bwb_if.sv
// Valid/ready channel interfaces for the request and response items.
// Depends on bwb_pkg for field widths.
interface bwb_req_if;
   logic                        valid;
   logic                        ready;
   logic [bwb_pkg::KIND_W-1:0]  kind;
   logic [bwb_pkg::BYTE_W-1:0]  data_byte;
   logic [bwb_pkg::POS_W-1:0]   position;

   modport source (output valid, kind, data_byte, position, input ready);
   modport sink   (input valid, kind, data_byte, position, output ready);
endinterface

interface bwb_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [bwb_pkg::BYTE_W-1:0]  read_value;
   logic [bwb_pkg::MIDX_W-1:0]  match_index;
   logic                        match_found;
   logic [bwb_pkg::FILL_W-1:0]  fill_level;

   modport source (output valid, read_value, match_index, match_found, fill_level,
                   input ready);
   modport sink   (input valid, read_value, match_index, match_found, fill_level,
                   output ready);
endinterface

FILE: src/byte_window_buffer_with_search.sv
// Byte window buffer with search: holds up to CAPACITY bytes in a ring store,
// index 0 being the oldest; append drops the oldest byte when full, remove
// discards through an index, search scans forward from an index for a byte
// value, read returns the byte at an index. Every request item yields exactly
// one response item carrying the fill level after the operation. Requests
// enter a two-entry command queue and are executed one at a time by the back
// end, which owns the single-port-write, registered-read byte store. Append
// and remove complete in the idle state, read waits in ST_READ_WAIT for the
// registered store data, and search steps through ST_SEARCH, one store read
// per cycle, then ST_RESULT. The store needs no clearing pass after reset.
// Depends on bwb_pkg, bwb_if, bwb_front and bwb_back.
module byte_window_buffer_with_search #(
   parameter int CAPACITY = bwb_pkg::DEFAULT_CAPACITY
) (
   input  logic      clock,
   input  logic      reset,
   bwb_req_if.sink   req,
   bwb_rsp_if.source rsp
);

   logic             q_valid;
   bwb_pkg::cmd_type q_cmd;
   logic             q_pop;

   bwb_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .q_valid (q_valid),
      .q_cmd   (q_cmd),
      .q_pop   (q_pop)
   );

   bwb_back #(
      .CAPACITY(CAPACITY)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_cmd   (q_cmd),
      .q_pop   (q_pop),
      .rsp     (rsp)
   );

endmodule

FILE: src/bwb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bwb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                                clock,
   input  logic                                we,
   input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
   input  logic [WIDTH-1:0]                    wdata,
   input  logic                                re,
   input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
   output logic [WIDTH-1:0]                    rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: src/bwb_front.sv
// Front end: accepts request items, decodes the kind and queues commands.
// Depends on bwb_pkg and bwb_req_if.
module bwb_front (
   input  logic             clock,
   input  logic             reset,
   bwb_req_if.sink          req,
   output logic             q_valid,
   output bwb_pkg::cmd_type q_cmd,
   input  logic             q_pop
);

   localparam int QD  = bwb_pkg::QUEUE_DEPTH;
   localparam int QPW = (QD > 1) ? $clog2(QD) : 1;
   localparam int QCW = $clog2(QD + 1);

   bwb_pkg::cmd_type entry_ff [QD];
   logic [QPW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0]   count_ff, count_in;
   bwb_pkg::cmd_type new_cmd;
   logic             push;
   logic             pop;

   always_comb begin
      new_cmd.data_byte = req.data_byte;
      new_cmd.position  = req.position;
      unique case (req.kind)
         bwb_pkg::OP_APPEND: new_cmd.op = bwb_pkg::OP_APPEND;
         bwb_pkg::OP_REMOVE: new_cmd.op = bwb_pkg::OP_REMOVE;
         bwb_pkg::OP_SEARCH: new_cmd.op = bwb_pkg::OP_SEARCH;
         default:            new_cmd.op = bwb_pkg::OP_READ;
      endcase
   end

   assign req.ready = (count_ff != QCW'(QD));
   assign push      = req.valid & req.ready;
   assign q_valid   = (count_ff != '0);
   assign q_cmd     = entry_ff[rd_ptr_ff];
   assign pop       = q_pop & q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPW'(QD - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPW'(QD - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

FILE: src/bwb_back.sv
// Back end: ring pointers, byte store, search sequencer and response register.
// Depends on bwb_pkg, bwb_rsp_if and bwb_ram.
module bwb_back #(
   parameter int CAPACITY = bwb_pkg::DEFAULT_CAPACITY
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  bwb_pkg::cmd_type q_cmd,
   output logic             q_pop,
   bwb_rsp_if.source        rsp
);

   localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int SW = CW + 1;
   localparam int XW = ((CW > bwb_pkg::POS_W) ? CW : bwb_pkg::POS_W) + 1;

   bwb_pkg::back_state_type    state_ff, state_in;
   logic [PW-1:0]              oldest_ff, oldest_in;
   logic [CW-1:0]              held_ff, held_in;
   logic [CW-1:0]              idx_ff, idx_in;
   logic [CW-1:0]              cmp_ff, cmp_in;
   logic [PW-1:0]              slot_ff, slot_in;
   logic [bwb_pkg::BYTE_W-1:0] key_ff, key_in;
   logic                       pend_ff, pend_in;
   logic                       found_ff, found_in;
   logic [CW-1:0]              ridx_ff, ridx_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [bwb_pkg::BYTE_W-1:0] rsp_read_ff;
   logic [bwb_pkg::MIDX_W-1:0] rsp_midx_ff;
   logic                       rsp_found_ff;
   logic [bwb_pkg::FILL_W-1:0] rsp_fill_ff;

   logic                       ram_we;
   logic [PW-1:0]              ram_waddr;
   logic                       ram_re;
   logic [PW-1:0]              ram_raddr;
   logic [bwb_pkg::BYTE_W-1:0] ram_rdata;

   logic                       out_free;
   logic                       in_range;
   logic                       full;
   logic [CW-1:0]              pos_cw;
   logic [CW-1:0]              rm_off;
   logic                       emit;
   logic [bwb_pkg::BYTE_W-1:0] emit_read;
   logic [CW-1:0]              emit_midx;
   logic                       emit_found;
   logic [31:0]                midx_wide;
   logic [31:0]                fill_wide;

   function automatic logic [PW-1:0] slot_add(input logic [PW-1:0] base,
                                              input logic [CW-1:0] off);
      logic [SW-1:0] sum;
      sum = SW'(base) + SW'(off);
      if (sum >= SW'(CAPACITY)) begin
         sum = sum - SW'(CAPACITY);
      end
      return sum[PW-1:0];
   endfunction

   bwb_ram #(
      .WIDTH(bwb_pkg::BYTE_W),
      .DEPTH(CAPACITY)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (q_cmd.data_byte),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign in_range = XW'(q_cmd.position) < XW'(held_ff);
   assign full     = (held_ff == CW'(CAPACITY));
   assign pos_cw   = CW'(q_cmd.position);
   assign rm_off   = pos_cw + 1'b1;

   always_comb begin
      state_in   = state_ff;
      oldest_in  = oldest_ff;
      held_in    = held_ff;
      idx_in     = idx_ff;
      cmp_in     = cmp_ff;
      slot_in    = slot_ff;
      key_in     = key_ff;
      pend_in    = 1'b0;
      found_in   = found_ff;
      ridx_in    = ridx_ff;
      q_pop      = 1'b0;
      ram_we     = 1'b0;
      ram_waddr  = oldest_ff;
      ram_re     = 1'b0;
      ram_raddr  = slot_ff;
      emit       = 1'b0;
      emit_read  = '0;
      emit_midx  = '0;
      emit_found = 1'b0;

      unique case (state_ff)
         bwb_pkg::ST_IDLE: begin
            if (q_valid) begin
               unique case (q_cmd.op)
                  bwb_pkg::OP_APPEND: begin
                     if (out_free) begin
                        q_pop  = 1'b1;
                        emit   = 1'b1;
                        ram_we = 1'b1;
                        if (full) begin
                           oldest_in = slot_add(oldest_ff, CW'(1));
                           ram_waddr = oldest_ff;
                        end else begin
                           ram_waddr = slot_add(oldest_ff, held_ff);
                           held_in   = held_ff + 1'b1;
                        end
                     end
                  end
                  bwb_pkg::OP_REMOVE: begin
                     if (out_free) begin
                        q_pop = 1'b1;
                        emit  = 1'b1;
                        if (in_range) begin
                           oldest_in = slot_add(oldest_ff, rm_off);
                           held_in   = held_ff - rm_off;
                        end else begin
                           oldest_in = '0;
                           held_in   = '0;
                        end
                     end
                  end
                  bwb_pkg::OP_SEARCH: begin
                     if (in_range) begin
                        q_pop    = 1'b1;
                        idx_in   = pos_cw;
                        slot_in  = slot_add(oldest_ff, pos_cw);
                        key_in   = q_cmd.data_byte;
                        state_in = bwb_pkg::ST_SEARCH;
                     end else if (out_free) begin
                        q_pop = 1'b1;
                        emit  = 1'b1;
                     end
                  end
                  default: begin
                     if (in_range) begin
                        q_pop     = 1'b1;
                        ram_re    = 1'b1;
                        ram_raddr = slot_add(oldest_ff, pos_cw);
                        state_in  = bwb_pkg::ST_READ_WAIT;
                     end else if (out_free) begin
                        q_pop = 1'b1;
                        emit  = 1'b1;
                     end
                  end
               endcase
            end
         end
         bwb_pkg::ST_READ_WAIT: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_read = ram_rdata;
               state_in  = bwb_pkg::ST_IDLE;
            end
         end
         bwb_pkg::ST_SEARCH: begin
            if (pend_ff && (ram_rdata == key_ff)) begin
               found_in = 1'b1;
               ridx_in  = cmp_ff;
               state_in = bwb_pkg::ST_RESULT;
            end else if (idx_ff < held_ff) begin
               ram_re    = 1'b1;
               ram_raddr = slot_ff;
               pend_in   = 1'b1;
               cmp_in    = idx_ff;
               idx_in    = idx_ff + 1'b1;
               slot_in   = (slot_ff == PW'(CAPACITY - 1)) ? '0 : slot_ff + 1'b1;
            end else begin
               found_in = 1'b0;
               ridx_in  = '0;
               state_in = bwb_pkg::ST_RESULT;
            end
         end
         default: begin
            if (out_free) begin
               emit       = 1'b1;
               emit_found = found_ff;
               emit_midx  = ridx_ff;
               state_in   = bwb_pkg::ST_IDLE;
            end
         end
      endcase
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp.ready);
   assign midx_wide    = 32'(emit_midx);
   assign fill_wide    = 32'(held_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bwb_pkg::ST_IDLE;
         oldest_ff    <= '0;
         held_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         oldest_ff    <= oldest_in;
         held_ff      <= held_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      cmp_ff   <= cmp_in;
      slot_ff  <= slot_in;
      key_ff   <= key_in;
      found_ff <= found_in;
      ridx_ff  <= ridx_in;
      if (emit) begin
         rsp_read_ff  <= emit_read;
         rsp_midx_ff  <= midx_wide[bwb_pkg::MIDX_W-1:0];
         rsp_found_ff <= emit_found;
         rsp_fill_ff  <= fill_wide[bwb_pkg::FILL_W-1:0];
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.read_value  = rsp_read_ff;
   assign rsp.match_index = rsp_midx_ff;
   assign rsp.match_found = rsp_found_ff;
   assign rsp.fill_level  = rsp_fill_ff;

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for byte_window_buffer_with_search: a queue-fed driver, a
// stalling receiver and a monitor that checks each response against a ring-buffer predictor.
// Depends on bwb_pkg, bwb_if and the RTL of the block.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY      = bwb_pkg::DEFAULT_CAPACITY;
   localparam int SLOT_W        = $clog2(CAPACITY);
   localparam int SETTLE_CYCLES = 40;
   localparam int MAX_REPORTS   = 10;
   localparam int HOLD_CYCLES   = 400;
   localparam int FILL_RUN      = 160;

   typedef struct packed {
      logic [bwb_pkg::BYTE_W-1:0] read_value;
      logic [bwb_pkg::MIDX_W-1:0] match_index;
      logic                       match_found;
      logic [bwb_pkg::FILL_W-1:0] fill_level;
   } outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bwb_req_if req ();
   bwb_rsp_if rsp ();

   byte_window_buffer_with_search #(.CAPACITY(CAPACITY)) dut (
      .clock(clock),
      .reset(reset),
      .req  (req),
      .rsp  (rsp)
   );

   logic [bwb_pkg::BYTE_W-1:0] window_bytes [CAPACITY];
   int unsigned                window_head;
   int unsigned                window_count;

   bwb_pkg::cmd_type pending_cmds [$];
   outcome_type      expected_outcomes [$];
   int unsigned      issued_count;
   int unsigned      taken_count;
   int unsigned      outcome_count;
   int unsigned      error_count;
   int unsigned      planned_fill;
   int unsigned      hold_left;
   int unsigned      holds_done;
   int unsigned      hold_points [2] = '{30, 250};
   bit               gaps_on;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic outcome_type apply_to_window(bwb_pkg::cmd_type cmd);
      outcome_type res;
      int unsigned idx;
      res = '0;
      case (cmd.op)
         bwb_pkg::OP_APPEND: begin
            if (window_count >= CAPACITY) begin
               window_head  = (window_head + 1) % CAPACITY;
               window_count = CAPACITY - 1;
            end
            window_bytes[SLOT_W'((window_head + window_count) % CAPACITY)] = cmd.data_byte;
            window_count++;
         end
         bwb_pkg::OP_REMOVE: begin
            if (cmd.position < window_count) begin
               window_head  = (window_head + cmd.position + 1) % CAPACITY;
               window_count = window_count - cmd.position - 1;
            end else begin
               window_head  = 0;
               window_count = 0;
            end
         end
         bwb_pkg::OP_SEARCH: begin
            for (idx = cmd.position; idx < window_count; idx++) begin
               if (window_bytes[SLOT_W'((window_head + idx) % CAPACITY)] == cmd.data_byte)
               begin
                  res.match_index = idx[bwb_pkg::MIDX_W-1:0];
                  res.match_found = 1'b1;
                  break;
               end
            end
         end
         bwb_pkg::OP_READ: begin
            if (cmd.position < window_count)
               res.read_value = window_bytes[SLOT_W'((window_head + cmd.position) % CAPACITY)];
         end
         default: ;
      endcase
      res.fill_level = window_count[bwb_pkg::FILL_W-1:0];
      return res;
   endfunction

   function automatic void report_error(string msg);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("%0t: %s", $realtime, msg);
   endfunction

   function automatic logic [bwb_pkg::BYTE_W-1:0] pick_byte();
      if ($urandom_range(1) == 0)
         return bwb_pkg::BYTE_W'($urandom_range(15));
      return bwb_pkg::BYTE_W'($urandom_range(255));
   endfunction

   function automatic logic [bwb_pkg::POS_W-1:0] pick_position(int unsigned fill);
      if (fill > 0 && $urandom_range(99) < 70)
         return bwb_pkg::POS_W'($urandom_range(fill - 1));
      return bwb_pkg::POS_W'($urandom_range(1023));
   endfunction

   task automatic queue_cmd(bwb_pkg::op_type op, logic [bwb_pkg::BYTE_W-1:0] value,
                            logic [bwb_pkg::POS_W-1:0] pos);
      bwb_pkg::cmd_type cmd;
      cmd.op        = op;
      cmd.data_byte = value;
      cmd.position  = pos;
      pending_cmds.push_back(cmd);
      case (op)
         bwb_pkg::OP_APPEND: if (planned_fill < CAPACITY) planned_fill++;
         bwb_pkg::OP_REMOVE: planned_fill = (pos < planned_fill) ? planned_fill - pos - 1 : 0;
         default: ;
      endcase
   endtask

   task automatic queue_random_cmd();
      int unsigned roll;
      logic [bwb_pkg::POS_W-1:0] pos;
      roll = $urandom_range(99);
      if (roll < 50) begin
         queue_cmd(bwb_pkg::OP_APPEND, pick_byte(), bwb_pkg::POS_W'($urandom_range(1023)));
      end else if (roll < 65) begin
         if ($urandom_range(99) < 75)
            pos = bwb_pkg::POS_W'($urandom_range(7));
         else
            pos = pick_position(planned_fill);
         queue_cmd(bwb_pkg::OP_REMOVE, pick_byte(), pos);
      end else if (roll < 82) begin
         queue_cmd(bwb_pkg::OP_SEARCH, pick_byte(), pick_position(planned_fill));
      end else begin
         queue_cmd(bwb_pkg::OP_READ, pick_byte(), pick_position(planned_fill));
      end
   endtask

   task automatic wait_drained();
      while (pending_cmds.size() > 0 || taken_count != issued_count)
         @(posedge clock);
   endtask

   // record accepted items and predict their responses
   always @(posedge clock) begin
      bwb_pkg::cmd_type cmd;
      if (!reset && req.valid && req.ready) begin
         cmd.op        = bwb_pkg::op_type'(req.kind);
         cmd.data_byte = req.data_byte;
         cmd.position  = req.position;
         expected_outcomes.push_back(apply_to_window(cmd));
         taken_count++;
      end
   end

   always @(posedge clock) begin
      outcome_type seen;
      outcome_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         seen.read_value  = rsp.read_value;
         seen.match_index = rsp.match_index;
         seen.match_found = rsp.match_found;
         seen.fill_level  = rsp.fill_level;
         outcome_count++;
         if (expected_outcomes.size() == 0) begin
            report_error($sformatf("unexpected response rv=%0d mi=%0d mf=%0d fill=%0d",
               seen.read_value, seen.match_index, seen.match_found, seen.fill_level));
         end else begin
            want = expected_outcomes.pop_front();
            if (seen.read_value !== want.read_value || seen.match_index !== want.match_index
                || seen.match_found !== want.match_found
                || seen.fill_level !== want.fill_level)
               report_error({
                  $sformatf("response %0d: expected rv=%0d mi=%0d mf=%0d fill=%0d,",
                     outcome_count, want.read_value, want.match_index, want.match_found,
                     want.fill_level),
                  $sformatf(" got rv=%0d mi=%0d mf=%0d fill=%0d",
                     seen.read_value, seen.match_index, seen.match_found,
                     seen.fill_level)});
         end
      end
   end

   // advance to the next item once the current one is taken; hold otherwise
   always @(negedge clock) begin
      bwb_pkg::cmd_type next_cmd;
      if (reset) begin
         req.valid <= 1'b0;
      end else if (taken_count == issued_count) begin
         if (pending_cmds.size() > 0 && !(gaps_on && $urandom_range(99) < 23)) begin
            next_cmd = pending_cmds.pop_front();
            req.valid     <= 1'b1;
            req.kind      <= next_cmd.op;
            req.data_byte <= next_cmd.data_byte;
            req.position  <= next_cmd.position;
            issued_count++;
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp.ready <= 1'b0;
         hold_left--;
      end else if (holds_done < 2 && outcome_count >= hold_points[holds_done]) begin
         rsp.ready <= 1'b0;
         hold_left = HOLD_CYCLES - 1;
         holds_done++;
      end else begin
         rsp.ready <= !(gaps_on && $urandom_range(99) < 23);
      end
   end

   initial begin
      req.valid     = 1'b0;
      req.kind      = bwb_pkg::OP_APPEND;
      req.data_byte = '0;
      req.position  = '0;
      rsp.ready     = 1'b0;
      gaps_on       = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      queue_cmd(bwb_pkg::OP_READ,   8'h00, 10'd0);
      queue_cmd(bwb_pkg::OP_SEARCH, 8'h00, 10'd0);
      queue_cmd(bwb_pkg::OP_REMOVE, 8'h00, 10'd0);
      queue_cmd(bwb_pkg::OP_APPEND, 8'h00, 10'd0);
      queue_cmd(bwb_pkg::OP_APPEND, 8'hFF, 10'd1023);
      queue_cmd(bwb_pkg::OP_APPEND, 8'hA5, 10'd0);
      queue_cmd(bwb_pkg::OP_APPEND, 8'h5A, 10'd0);
      queue_cmd(bwb_pkg::OP_READ,   8'h00, 10'd0);
      queue_cmd(bwb_pkg::OP_READ,   8'h00, 10'd1);
      queue_cmd(bwb_pkg::OP_READ,   8'h00, 10'd3);
      queue_cmd(bwb_pkg::OP_READ,   8'h00, 10'd4);
      queue_cmd(bwb_pkg::OP_READ,   8'hFF, 10'd1023);
      queue_cmd(bwb_pkg::OP_SEARCH, 8'hFF, 10'd0);
      queue_cmd(bwb_pkg::OP_SEARCH, 8'hFF, 10'd2);
      queue_cmd(bwb_pkg::OP_SEARCH, 8'h5A, 10'd1023);
      queue_cmd(bwb_pkg::OP_SEARCH, 8'h00, 10'd0);
      queue_cmd(bwb_pkg::OP_REMOVE, 8'h00, 10'd0);
      queue_cmd(bwb_pkg::OP_READ,   8'h00, 10'd0);
      queue_cmd(bwb_pkg::OP_REMOVE, 8'hFF, 10'd1023);
      queue_cmd(bwb_pkg::OP_APPEND, 8'h3C, 10'd0);
      queue_cmd(bwb_pkg::OP_REMOVE, 8'h00, 10'd0);
      wait_drained();

      repeat (120) queue_random_cmd();
      wait_drained();

      gaps_on = 1'b0;
      repeat (FILL_RUN)
         queue_cmd(bwb_pkg::OP_APPEND, pick_byte(), bwb_pkg::POS_W'($urandom_range(1023)));
      repeat (40) queue_random_cmd();
      wait_drained();

      gaps_on = 1'b1;
      repeat (60) queue_random_cmd();
      wait_drained();

      while (expected_outcomes.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #50_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
